FILE: hw/rtl/vrp_pkg.sv
package vrp_pkg;

    localparam int VRP_SPRITE_BYTES    = 256;
    localparam int VRP_PALETTE_ENTRIES = 32;

    typedef enum logic [1:0] {
        CMD_READ      = 2'd0,
        CMD_WRITE     = 2'd1,
        CMD_VBL_BEGIN = 2'd2,
        CMD_VBL_END   = 2'd3
    } vrp_cmd_t;

    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    localparam logic [2:0] VAR_STANDARD = 3'd0;
    localparam logic [2:0] VAR_EARLY    = 3'd1;
    localparam logic [2:0] VAR_ARC1     = 3'd2;
    localparam logic [2:0] VAR_ARC2     = 3'd3;
    localparam logic [2:0] VAR_ARC3     = 3'd4;
    localparam logic [2:0] VAR_ARC4     = 3'd5;
    localparam logic [2:0] VAR_ARC5     = 3'd6;

    localparam logic [7:0]  ID_ARC_A      = 8'h1b;
    localparam logic [7:0]  ID_ARC_B      = 8'h3d;
    localparam logic [7:0]  ID_ARC_C      = 8'h1c;
    localparam logic [7:0]  PAL_GRAY_MASK = 8'h30;
    localparam logic [7:0]  LATCH_KEEP    = 8'hc0;
    localparam logic [7:0]  OAM_ATTR_MASK = 8'he3;
    localparam logic [5:0]  PAL_PAGE      = 6'h3f;
    localparam logic [14:0] STEP_ACROSS   = 15'd1;
    localparam logic [14:0] STEP_DOWN     = 15'd32;

    typedef struct packed {
        vrp_cmd_t   cmd;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic [7:0] chr_read_data;
        logic       rendering_active;
        logic       sprite_overflow;
        logic       sprite_zero_hit;
    } vrp_item_t;

    typedef struct packed {
        logic [7:0]  data_latch;
        logic [7:0]  read_buffer;
        logic [14:0] vram_address;
        logic [14:0] temp_address;
        logic [2:0]  fine_x;
        logic        write_toggle;
        logic [5:0]  control_bits;
        logic [7:0]  mask_bits;
        logic [7:0]  sprite_addr;
        logic        vblank_flag;
        logic        vblank_hold;
    } vrp_state_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        nmi_line;
        logic [13:0] chr_address;
        logic        chr_write;
        logic [7:0]  chr_write_data;
        logic [5:0]  ctrl_flags;
        logic [7:0]  mask_flags;
        logic [14:0] scroll_temp;
        logic [2:0]  fine_scroll_x;
    } vrp_result_t;

endpackage

FILE: hw/rtl/vrp_exec.sv
module vrp_exec #(
    parameter int SPRITE_BYTES    = vrp_pkg::VRP_SPRITE_BYTES,
    parameter int PALETTE_ENTRIES = vrp_pkg::VRP_PALETTE_ENTRIES,
    localparam int SPR_AW = $clog2(SPRITE_BYTES),
    localparam int PAL_AW = $clog2(PALETTE_ENTRIES)
) (
    input  logic                 fire,
    input  logic [2:0]           chip_variant,
    input  vrp_pkg::vrp_item_t   item,
    input  vrp_pkg::vrp_state_t  state_cur,
    input  logic [7:0]           sprite_rdata,
    input  logic [7:0]           palette_rdata,
    output vrp_pkg::vrp_state_t  state_next,
    output vrp_pkg::vrp_result_t result,
    output logic                 sprite_we,
    output logic [SPR_AW-1:0]    sprite_waddr,
    output logic [7:0]           sprite_wdata,
    output logic [SPR_AW-1:0]    sprite_raddr,
    output logic                 palette_we,
    output logic [PAL_AW-1:0]    palette_waddr,
    output logic [7:0]           palette_wdata,
    output logic [PAL_AW-1:0]    palette_raddr
);
    import vrp_pkg::*;

    function automatic logic [PAL_AW-1:0] pal_index(input logic [13:0] a);
        logic [PAL_AW-1:0] i;
        i = a[PAL_AW-1:0];
        if (i[1:0] == 2'b00)
        begin
            i[PAL_AW-1] = 1'b0;
        end
        return i;
    endfunction

    vrp_state_t  s;
    vrp_result_t r;
    logic        arcade;
    logic [2:0]  reg_eff;
    logic [13:0] vaddr;
    logic        pal_range;
    logic [14:0] vram_step;
    logic [7:0]  pal_byte;
    logic [7:0]  status_low;
    logic        spr_we;
    logic [7:0]  spr_wd;
    logic        pal_we;

    always_comb
    begin
        arcade    = (chip_variant >= VAR_ARC1) && (chip_variant <= VAR_ARC5);
        vaddr     = state_cur.vram_address[13:0];
        pal_range = (vaddr[13:8] == PAL_PAGE);
        vram_step = state_cur.vram_address
                    + (state_cur.control_bits[0] ? STEP_DOWN : STEP_ACROSS);
        pal_byte  = palette_rdata & (state_cur.mask_bits[0] ? PAL_GRAY_MASK : 8'hff);

        reg_eff = item.reg_select;
        if (arcade && (item.reg_select[2:1] == 2'b00))
        begin
            reg_eff[0] = ~item.reg_select[0];
        end

        unique case (chip_variant)
            VAR_ARC1, VAR_ARC4: status_low = ID_ARC_A;
            VAR_ARC2:           status_low = ID_ARC_B;
            VAR_ARC3:           status_low = ID_ARC_C;
            default:            status_low = {2'b00, item.sprite_overflow,
                                              state_cur.data_latch[4:0]};
        endcase

        s      = state_cur;
        spr_we = 1'b0;
        spr_wd = item.write_data;
        pal_we = 1'b0;
        r      = '0;
        r.read_data = state_cur.data_latch;

        unique case (item.cmd)
            CMD_READ:
            begin
                unique case (item.reg_select)
                    REG_STATUS:
                    begin
                        r.read_data    = status_low
                                         | {state_cur.vblank_flag, item.sprite_zero_hit, 6'd0};
                        s.write_toggle = 1'b0;
                        s.vblank_flag  = 1'b0;
                        s.vblank_hold  = 1'b0;
                    end
                    REG_OAM_DATA:
                    begin
                        if (chip_variant != VAR_EARLY)
                        begin
                            s.data_latch = sprite_rdata;
                        end
                        r.read_data = s.data_latch;
                    end
                    REG_DATA:
                    begin
                        if (item.rendering_active)
                        begin
                            r.read_data = 8'd0;
                        end
                        else
                        begin
                            if (pal_range)
                            begin
                                s.data_latch = (state_cur.data_latch & LATCH_KEEP) | pal_byte;
                            end
                            else
                            begin
                                s.data_latch = state_cur.read_buffer;
                            end
                            s.read_buffer  = item.chr_read_data;
                            s.vram_address = vram_step;
                            r.read_data    = s.data_latch;
                        end
                    end
                    default:
                    begin
                        r.read_data = state_cur.data_latch;
                    end
                endcase
            end
            CMD_WRITE:
            begin
                s.data_latch = item.write_data;
                r.read_data  = item.write_data;
                unique case (reg_eff)
                    REG_CTRL:
                    begin
                        s.temp_address[11:10] = item.write_data[1:0];
                        s.control_bits        = item.write_data[7:2];
                    end
                    REG_MASK:
                    begin
                        s.mask_bits = item.write_data;
                    end
                    REG_STATUS:
                    begin
                        s.data_latch = item.write_data;
                    end
                    REG_OAM_ADDR:
                    begin
                        s.sprite_addr = item.write_data;
                    end
                    REG_OAM_DATA:
                    begin
                        spr_we = 1'b1;
                        if (state_cur.sprite_addr[1:0] == 2'b10)
                        begin
                            spr_wd = item.write_data & OAM_ATTR_MASK;
                        end
                        s.sprite_addr = state_cur.sprite_addr + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        if (!state_cur.write_toggle)
                        begin
                            s.fine_x            = item.write_data[2:0];
                            s.temp_address[4:0] = item.write_data[7:3];
                        end
                        else
                        begin
                            s.temp_address[14:12] = item.write_data[2:0];
                            s.temp_address[9:5]   = item.write_data[7:3];
                        end
                        s.write_toggle = ~state_cur.write_toggle;
                    end
                    REG_ADDR:
                    begin
                        if (!state_cur.write_toggle)
                        begin
                            s.temp_address[14]   = 1'b0;
                            s.temp_address[13:8] = item.write_data[5:0];
                        end
                        else
                        begin
                            s.temp_address[7:0] = item.write_data;
                            s.vram_address      = {state_cur.temp_address[14:8],
                                                   item.write_data};
                        end
                        s.write_toggle = ~state_cur.write_toggle;
                    end
                    REG_DATA:
                    begin
                        if (!item.rendering_active)
                        begin
                            if (pal_range)
                            begin
                                pal_we = 1'b1;
                            end
                            else
                            begin
                                r.chr_write      = 1'b1;
                                r.chr_write_data = item.write_data;
                            end
                            s.vram_address = vram_step;
                        end
                    end
                endcase
            end
            CMD_VBL_BEGIN:
            begin
                s.vblank_flag = 1'b1;
                s.vblank_hold = 1'b1;
            end
            CMD_VBL_END:
            begin
                s.vblank_flag = 1'b0;
                s.vblank_hold = 1'b0;
            end
        endcase

        // Data-port accesses show the address they used; everything else shows the new address.
        if (((item.cmd == CMD_READ) || (item.cmd == CMD_WRITE))
            && (item.reg_select == REG_DATA))
        begin
            r.chr_address = vaddr;
        end
        else
        begin
            r.chr_address = s.vram_address[13:0];
        end

        r.nmi_line      = s.control_bits[5] & s.vblank_flag & s.vblank_hold;
        r.ctrl_flags    = s.control_bits;
        r.mask_flags    = s.mask_bits;
        r.scroll_temp   = s.temp_address;
        r.fine_scroll_x = s.fine_x;

        state_next    = fire ? s : state_cur;
        result        = r;
        sprite_we     = fire & spr_we;
        sprite_waddr  = state_cur.sprite_addr[SPR_AW-1:0];
        sprite_wdata  = spr_wd;
        palette_we    = fire & pal_we;
        palette_waddr = pal_index(vaddr);
        palette_wdata = item.write_data;
        sprite_raddr  = state_next.sprite_addr[SPR_AW-1:0];
        palette_raddr = pal_index(state_next.vram_address[13:0]);
    end

endmodule

FILE: hw/rtl/video_register_port_top.sv
// Channel  | Handshake                    | Payload
// config   | cfg_write                    | cfg_data (chip variant)
// input    | in_valid / in_stall          | cmd, reg_select, write_data, chr_read_data,
//          |                              | rendering_active, sprite_overflow, sprite_zero_hit
// output   | out_valid / out_stall        | read_data, nmi_line, chr_address, chr_write,
//          |                              | chr_write_data, ctrl_flags, mask_flags,
//          |                              | scroll_temp, fine_scroll_x
// One item is taken per cycle while in_stall is low; the item and then its result are
// registered. The sprite and palette memories are read when the item is transferred
// and the item is executed from the registered read data, with writes forwarded.
// Reset clears the state, item and result registers; both memories hold unknown data
// until written.
// A stalled output holds its result and the stall reaches the input in the same cycle.
module video_register_port_top #(
    parameter int SPRITE_BYTES    = vrp_pkg::VRP_SPRITE_BYTES,
    parameter int PALETTE_ENTRIES = vrp_pkg::VRP_PALETTE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [2:0]  reg_select,
    input  logic [7:0]  write_data,
    input  logic [7:0]  chr_read_data,
    input  logic        rendering_active,
    input  logic        sprite_overflow,
    input  logic        sprite_zero_hit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        nmi_line,
    output logic [13:0] chr_address,
    output logic        chr_write,
    output logic [7:0]  chr_write_data,
    output logic [5:0]  ctrl_flags,
    output logic [7:0]  mask_flags,
    output logic [14:0] scroll_temp,
    output logic [2:0]  fine_scroll_x
);
    import vrp_pkg::*;

    localparam int SPR_AW = $clog2(SPRITE_BYTES);
    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    logic [2:0]        variant_reg;
    logic              s1_valid_reg;
    vrp_item_t         item_reg;
    vrp_state_t        state_reg;
    vrp_state_t        state_next;
    logic [7:0]        sprite_rd_reg;
    logic [7:0]        palette_rd_reg;
    logic              out_valid_reg;
    vrp_result_t       result_reg;
    vrp_result_t       result;

    logic [7:0]        sprite_mem  [SPRITE_BYTES];
    logic [7:0]        palette_mem [PALETTE_ENTRIES];

    logic              s1_fire;
    logic              in_accept;
    logic              sprite_we;
    logic [SPR_AW-1:0] sprite_waddr;
    logic [7:0]        sprite_wdata;
    logic [SPR_AW-1:0] sprite_raddr;
    logic              palette_we;
    logic [PAL_AW-1:0] palette_waddr;
    logic [7:0]        palette_wdata;
    logic [PAL_AW-1:0] palette_raddr;

    assign s1_fire   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign in_accept = in_valid && !in_stall;

    vrp_exec #(
        .SPRITE_BYTES    (SPRITE_BYTES),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_exec (
        .fire          (s1_fire),
        .chip_variant  (variant_reg),
        .item          (item_reg),
        .state_cur     (state_reg),
        .sprite_rdata  (sprite_rd_reg),
        .palette_rdata (palette_rd_reg),
        .state_next    (state_next),
        .result        (result),
        .sprite_we     (sprite_we),
        .sprite_waddr  (sprite_waddr),
        .sprite_wdata  (sprite_wdata),
        .sprite_raddr  (sprite_raddr),
        .palette_we    (palette_we),
        .palette_waddr (palette_waddr),
        .palette_wdata (palette_wdata),
        .palette_raddr (palette_raddr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg   <= VAR_STANDARD;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                variant_reg <= cfg_data;
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg   <= '0;
            result_reg <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                item_reg.cmd              <= vrp_cmd_t'(cmd);
                item_reg.reg_select       <= reg_select;
                item_reg.write_data       <= write_data;
                item_reg.chr_read_data    <= chr_read_data;
                item_reg.rendering_active <= rendering_active;
                item_reg.sprite_overflow  <= sprite_overflow;
                item_reg.sprite_zero_hit  <= sprite_zero_hit;
            end
            if (s1_fire)
            begin
                result_reg <= result;
            end
        end
    end

    // A write landing on the entry being read in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (sprite_we)
        begin
            sprite_mem[sprite_waddr] <= sprite_wdata;
        end
        if (in_accept)
        begin
            if (sprite_we && (sprite_waddr == sprite_raddr))
            begin
                sprite_rd_reg <= sprite_wdata;
            end
            else
            begin
                sprite_rd_reg <= sprite_mem[sprite_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (palette_we)
        begin
            palette_mem[palette_waddr] <= palette_wdata;
        end
        if (in_accept)
        begin
            if (palette_we && (palette_waddr == palette_raddr))
            begin
                palette_rd_reg <= palette_wdata;
            end
            else
            begin
                palette_rd_reg <= palette_mem[palette_raddr];
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = result_reg.read_data;
    assign nmi_line       = result_reg.nmi_line;
    assign chr_address    = result_reg.chr_address;
    assign chr_write      = result_reg.chr_write;
    assign chr_write_data = result_reg.chr_write_data;
    assign ctrl_flags     = result_reg.ctrl_flags;
    assign mask_flags     = result_reg.mask_flags;
    assign scroll_temp    = result_reg.scroll_temp;
    assign fine_scroll_x  = result_reg.fine_scroll_x;

endmodule

FILE: hw/rtl/vrp_checker.sv
module vrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  read_data,
    input logic        nmi_line,
    input logic [13:0] chr_address,
    input logic        chr_write,
    input logic [7:0]  chr_write_data,
    input logic [5:0]  ctrl_flags
);
    import vrp_pkg::*;

    // A bus write never targets the palette page.
    a_write_not_palette: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chr_write |-> chr_address[13:8] != PAL_PAGE)
        else $error("Video bus write into palette page.");

    a_write_data_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !chr_write |-> chr_write_data == 8'd0)
        else $error("Write data not zero without a bus write.");

    a_nmi_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && nmi_line |-> ctrl_flags[5])
        else $error("Interrupt raised with interrupt enable clear.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data)
                                   && $stable(chr_address))
        else $error("Stalled result transfer changed.");

endmodule

bind video_register_port_top vrp_checker u_vrp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .nmi_line       (nmi_line),
    .chr_address    (chr_address),
    .chr_write      (chr_write),
    .chr_write_data (chr_write_data),
    .ctrl_flags     (ctrl_flags)
);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import vrp_pkg::*;

    localparam int SHADOW  = 0;
    localparam int CHECKER = 1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_data = 3'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall = 1'b0;
    vrp_item_t   in_item = '0;
    logic [1:0]  cmd;
    logic [2:0]  reg_select;
    logic [7:0]  write_data;
    logic [7:0]  chr_read_data;
    logic        rendering_active;
    logic        sprite_overflow;
    logic        sprite_zero_hit;
    logic [7:0]  read_data;
    logic        nmi_line;
    logic [13:0] chr_address;
    logic        chr_write;
    logic [7:0]  chr_write_data;
    logic [5:0]  ctrl_flags;
    logic [7:0]  mask_flags;
    logic [14:0] scroll_temp;
    logic [2:0]  fine_scroll_x;

    vrp_state_t  port_regs [2];
    logic [2:0]  variant [2];
    logic [7:0]  oam_mem [2][VRP_SPRITE_BYTES];
    bit          oam_set [2][VRP_SPRITE_BYTES];
    logic [7:0]  pal_mem [2][VRP_PALETTE_ENTRIES];
    bit          pal_set [2][VRP_PALETTE_ENTRIES];

    vrp_item_t   pending_items [$];
    vrp_result_t port_results_due [$];
    vrp_result_t due;
    int          items_taken = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          holdoff_left = 0;
    bit          holdoff_done = 1'b0;

    assign cmd              = in_item.cmd;
    assign reg_select       = in_item.reg_select;
    assign write_data       = in_item.write_data;
    assign chr_read_data    = in_item.chr_read_data;
    assign rendering_active = in_item.rendering_active;
    assign sprite_overflow  = in_item.sprite_overflow;
    assign sprite_zero_hit  = in_item.sprite_zero_hit;

    video_register_port_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .reg_select       (reg_select),
        .write_data       (write_data),
        .chr_read_data    (chr_read_data),
        .rendering_active (rendering_active),
        .sprite_overflow  (sprite_overflow),
        .sprite_zero_hit  (sprite_zero_hit),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .read_data        (read_data),
        .nmi_line         (nmi_line),
        .chr_address      (chr_address),
        .chr_write        (chr_write),
        .chr_write_data   (chr_write_data),
        .ctrl_flags       (ctrl_flags),
        .mask_flags       (mask_flags),
        .scroll_temp      (scroll_temp),
        .fine_scroll_x    (fine_scroll_x)
    );

    always #5 clk = ~clk;

    function automatic logic [4:0] pal_slot(input logic [13:0] a);
        pal_slot = a[4:0];
        if (a[4] && a[1:0] == 2'b00)
            pal_slot[4] = 1'b0;
    endfunction

    // Applies one item to register copy s and returns the outputs it produces.
    function automatic vrp_result_t step_port(input int s, input vrp_item_t it);
        vrp_state_t  st;
        vrp_result_t res;
        logic [2:0]  rs;
        logic [13:0] a;
        logic [7:0]  v;
        bit          arcade;
        st = port_regs[s];
        rs = it.reg_select;
        a = st.vram_address[13:0];
        arcade = variant[s] >= VAR_ARC1 && variant[s] <= VAR_ARC5;
        res = '0;
        res.read_data = st.data_latch;
        case (it.cmd)
            CMD_READ:
            begin
                if (rs == REG_STATUS)
                begin
                    if (variant[s] == VAR_ARC1 || variant[s] == VAR_ARC4)
                        v = ID_ARC_A;
                    else if (variant[s] == VAR_ARC2)
                        v = ID_ARC_B;
                    else if (variant[s] == VAR_ARC3)
                        v = ID_ARC_C;
                    else
                        v = {2'b00, it.sprite_overflow, st.data_latch[4:0]};
                    v = v | {st.vblank_flag, it.sprite_zero_hit, 6'b000000};
                    st.write_toggle = 1'b0;
                    st.vblank_hold = 1'b0;
                    st.vblank_flag = 1'b0;
                    res.read_data = v;
                end
                else if (rs == REG_OAM_DATA)
                begin
                    if (variant[s] != VAR_EARLY)
                        st.data_latch = oam_mem[s][st.sprite_addr];
                    res.read_data = st.data_latch;
                end
                else if (rs == REG_DATA)
                begin
                    if (it.rendering_active)
                        res.read_data = 8'h00;
                    else
                    begin
                        if (a[13:8] != PAL_PAGE)
                            st.data_latch = st.read_buffer;
                        else
                        begin
                            v = pal_mem[s][pal_slot(a)];
                            if (st.mask_bits[0])
                                v = v & PAL_GRAY_MASK;
                            st.data_latch = (st.data_latch & LATCH_KEEP) | v;
                        end
                        st.read_buffer = it.chr_read_data;
                        st.vram_address = st.vram_address
                            + (st.control_bits[0] ? STEP_DOWN : STEP_ACROSS);
                        res.read_data = st.data_latch;
                    end
                end
            end
            CMD_WRITE:
            begin
                st.data_latch = it.write_data;
                if (arcade && rs <= REG_MASK)
                    rs[0] = ~rs[0];
                case (rs)
                    REG_CTRL:
                    begin
                        st.temp_address[11:10] = it.write_data[1:0];
                        st.control_bits = it.write_data[7:2];
                    end
                    REG_MASK:
                        st.mask_bits = it.write_data;
                    REG_OAM_ADDR:
                        st.sprite_addr = it.write_data;
                    REG_OAM_DATA:
                    begin
                        v = it.write_data;
                        if (st.sprite_addr[1:0] == 2'd2)
                            v = v & OAM_ATTR_MASK;
                        oam_mem[s][st.sprite_addr] = v;
                        oam_set[s][st.sprite_addr] = 1'b1;
                        st.sprite_addr = st.sprite_addr + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        if (!st.write_toggle)
                        begin
                            st.fine_x = it.write_data[2:0];
                            st.temp_address[4:0] = it.write_data[7:3];
                        end
                        else
                        begin
                            st.temp_address[14:12] = it.write_data[2:0];
                            st.temp_address[9:5] = it.write_data[7:3];
                        end
                        st.write_toggle = ~st.write_toggle;
                    end
                    REG_ADDR:
                    begin
                        if (!st.write_toggle)
                        begin
                            st.temp_address[14] = 1'b0;
                            st.temp_address[13:8] = it.write_data[5:0];
                        end
                        else
                        begin
                            st.temp_address[7:0] = it.write_data;
                            st.vram_address = st.temp_address;
                        end
                        st.write_toggle = ~st.write_toggle;
                    end
                    REG_DATA:
                    begin
                        if (!it.rendering_active)
                        begin
                            if (a[13:8] != PAL_PAGE)
                            begin
                                res.chr_write = 1'b1;
                                res.chr_write_data = it.write_data;
                            end
                            else
                            begin
                                pal_mem[s][pal_slot(a)] = it.write_data;
                                pal_set[s][pal_slot(a)] = 1'b1;
                            end
                            st.vram_address = st.vram_address
                                + (st.control_bits[0] ? STEP_DOWN : STEP_ACROSS);
                        end
                    end
                    default:
                        ;
                endcase
                res.read_data = st.data_latch;
            end
            CMD_VBL_BEGIN:
            begin
                st.vblank_flag = 1'b1;
                st.vblank_hold = 1'b1;
            end
            default:
            begin
                st.vblank_flag = 1'b0;
                st.vblank_hold = 1'b0;
            end
        endcase
        if ((it.cmd == CMD_READ || it.cmd == CMD_WRITE) && it.reg_select == REG_DATA)
            res.chr_address = a;
        else
            res.chr_address = st.vram_address[13:0];
        res.nmi_line = st.control_bits[5] & st.vblank_flag & st.vblank_hold;
        res.ctrl_flags = st.control_bits;
        res.mask_flags = st.mask_bits;
        res.scroll_temp = st.temp_address;
        res.fine_scroll_x = st.fine_x;
        port_regs[s] = st;
        return res;
    endfunction

    function automatic vrp_item_t mk(input vrp_cmd_t c, input logic [2:0] r,
                                     input logic [7:0] d);
        vrp_item_t it;
        it.cmd = c;
        it.reg_select = r;
        it.write_data = d;
        it.chr_read_data = 8'($urandom);
        it.rendering_active = 1'b0;
        it.sprite_overflow = 1'($urandom);
        it.sprite_zero_hit = 1'($urandom);
        return it;
    endfunction

    // Reads of sprite or palette entries that were never written are turned into writes.
    task automatic offer(input vrp_item_t it);
        vrp_state_t st;
        st = port_regs[SHADOW];
        if (it.cmd == CMD_READ && it.reg_select == REG_OAM_DATA
            && variant[SHADOW] != VAR_EARLY && !oam_set[SHADOW][st.sprite_addr])
            it.cmd = CMD_WRITE;
        if (it.cmd == CMD_READ && it.reg_select == REG_DATA && !it.rendering_active
            && st.vram_address[13:8] == PAL_PAGE
            && !pal_set[SHADOW][pal_slot(st.vram_address[13:0])])
            it.cmd = CMD_WRITE;
        void'(step_port(SHADOW, it));
        pending_items.push_back(it);
    endtask

    task automatic random_burst(input int n);
        vrp_item_t  it;
        int         made;
        int         k;
        logic [7:0] hi;
        made = 0;
        while (made < n)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    it = mk(vrp_cmd_t'($urandom_range(0, 3)), 3'($urandom), 8'($urandom));
                    it.rendering_active = 1'($urandom);
                    offer(it);
                    made++;
                end
                2, 3, 4:
                begin
                    offer(mk(CMD_READ, REG_STATUS, 8'($urandom)));
                    hi = 8'($urandom);
                    if ($urandom_range(0, 1))
                        hi[5:0] = PAL_PAGE;
                    offer(mk(CMD_WRITE, REG_ADDR, hi));
                    offer(mk(CMD_WRITE, REG_ADDR, 8'($urandom)));
                    k = $urandom_range(1, 8);
                    repeat (k)
                    begin
                        it = mk($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, REG_DATA,
                                8'($urandom));
                        it.rendering_active = ($urandom_range(0, 7) == 0);
                        offer(it);
                    end
                    made += 3 + k;
                end
                5:
                begin
                    offer(mk(CMD_READ, REG_STATUS, 8'($urandom)));
                    offer(mk(CMD_WRITE, REG_SCROLL, 8'($urandom)));
                    offer(mk(CMD_WRITE, REG_SCROLL, 8'($urandom)));
                    made += 3;
                end
                6:
                begin
                    offer(mk(CMD_WRITE, REG_OAM_ADDR, 8'($urandom)));
                    k = $urandom_range(1, 6);
                    repeat (k)
                        offer(mk($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, REG_OAM_DATA,
                                 8'($urandom)));
                    made += 1 + k;
                end
                7:
                begin
                    offer(mk(CMD_WRITE, $urandom_range(0, 1) ? REG_CTRL : REG_MASK,
                             8'($urandom)));
                    made++;
                end
                8:
                begin
                    offer(mk(CMD_VBL_BEGIN, 3'($urandom), 8'($urandom)));
                    offer(mk(CMD_WRITE, REG_CTRL, 8'($urandom)));
                    offer(mk(CMD_READ, REG_STATUS, 8'($urandom)));
                    offer(mk(CMD_VBL_END, 3'($urandom), 8'($urandom)));
                    made += 4;
                end
                default:
                begin
                    offer(mk(CMD_WRITE, $urandom_range(0, 1) ? REG_ADDR : REG_SCROLL,
                             8'($urandom)));
                    offer(mk(vrp_cmd_t'($urandom_range(0, 1)), REG_DATA, 8'($urandom)));
                    made += 2;
                end
            endcase
        end
    endtask

    // The check is made just after each edge, once that edge's updates have settled.
    task automatic drain;
        @(posedge clk);
        #1;
        while (pending_items.size() != 0 || in_valid || port_results_due.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
    endtask

    task automatic set_variant(input logic [2:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        variant[SHADOW] = v;
        variant[CHECKER] = v;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                port_results_due.push_back(step_port(CHECKER, in_item));
                items_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0
                    && ((items_taken >= 600 && items_taken < 850)
                        || $urandom_range(0, 99) >= 13))
                begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (port_results_due.size() == 0)
                begin
                    $error("result transfer with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    due = port_results_due.pop_front();
                    check_field("read_data", 16'(due.read_data), 16'(read_data));
                    check_field("nmi_line", 16'(due.nmi_line), 16'(nmi_line));
                    check_field("chr_address", 16'(due.chr_address), 16'(chr_address));
                    check_field("chr_write", 16'(due.chr_write), 16'(chr_write));
                    check_field("chr_write_data", 16'(due.chr_write_data),
                                16'(chr_write_data));
                    check_field("ctrl_flags", 16'(due.ctrl_flags), 16'(ctrl_flags));
                    check_field("mask_flags", 16'(due.mask_flags), 16'(mask_flags));
                    check_field("scroll_temp", 16'(due.scroll_temp), 16'(scroll_temp));
                    check_field("fine_scroll_x", 16'(due.fine_scroll_x),
                                16'(fine_scroll_x));
                end
                results_seen++;
            end
            if (holdoff_left > 0)
            begin
                out_stall <= 1'b1;
                holdoff_left--;
            end
            else if (!holdoff_done && results_seen >= 250 && pending_items.size() > 40)
            begin
                holdoff_done = 1'b1;
                holdoff_left = 80;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !(results_seen >= 600 && results_seen < 850)
                             && $urandom_range(0, 99) < 13;
        end
    end

    initial
    begin
        vrp_item_t it;
        port_regs[SHADOW] = '0;
        port_regs[CHECKER] = '0;
        variant[SHADOW] = VAR_STANDARD;
        variant[CHECKER] = VAR_STANDARD;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        set_variant(VAR_STANDARD);

        offer(mk(CMD_WRITE, REG_CTRL, 8'hff));
        offer(mk(CMD_VBL_BEGIN, REG_CTRL, 8'h00));
        it = mk(CMD_READ, REG_STATUS, 8'h00);
        it.sprite_overflow = 1'b1;
        it.sprite_zero_hit = 1'b1;
        offer(it);
        offer(mk(CMD_VBL_END, REG_CTRL, 8'h00));
        offer(mk(CMD_WRITE, REG_CTRL, 8'h00));
        offer(mk(CMD_WRITE, REG_SCROLL, 8'hff));
        offer(mk(CMD_WRITE, REG_SCROLL, 8'h00));
        offer(mk(CMD_WRITE, REG_ADDR, 8'hff));
        offer(mk(CMD_WRITE, REG_ADDR, 8'h00));
        offer(mk(CMD_WRITE, REG_DATA, 8'hff));
        // The backdrop mirror reads back the entry written at the start of the palette.
        offer(mk(CMD_WRITE, REG_ADDR, 8'h3f));
        offer(mk(CMD_WRITE, REG_ADDR, 8'h10));
        offer(mk(CMD_READ, REG_DATA, 8'h00));
        offer(mk(CMD_WRITE, REG_MASK, 8'hff));
        offer(mk(CMD_WRITE, REG_ADDR, 8'h3f));
        offer(mk(CMD_WRITE, REG_ADDR, 8'h10));
        offer(mk(CMD_READ, REG_DATA, 8'h00));
        it = mk(CMD_WRITE, REG_DATA, 8'h55);
        it.rendering_active = 1'b1;
        offer(it);
        it = mk(CMD_READ, REG_DATA, 8'h00);
        it.rendering_active = 1'b1;
        offer(it);
        offer(mk(CMD_WRITE, REG_ADDR, 8'h20));
        offer(mk(CMD_WRITE, REG_ADDR, 8'h00));
        offer(mk(CMD_WRITE, REG_DATA, 8'haa));
        offer(mk(CMD_READ, REG_DATA, 8'h00));
        offer(mk(CMD_WRITE, REG_OAM_ADDR, 8'h02));
        offer(mk(CMD_WRITE, REG_OAM_DATA, 8'hff));
        offer(mk(CMD_WRITE, REG_OAM_ADDR, 8'h02));
        offer(mk(CMD_READ, REG_OAM_DATA, 8'h00));
        offer(mk(CMD_WRITE, REG_STATUS, 8'h5a));
        drain;

        set_variant(VAR_EARLY);
        random_burst(155);
        drain;
        set_variant(VAR_ARC1);
        random_burst(155);
        drain;
        set_variant(VAR_ARC2);
        random_burst(155);
        drain;
        set_variant(VAR_ARC3);
        random_burst(155);
        drain;
        set_variant(VAR_ARC4);
        random_burst(155);
        drain;
        set_variant(VAR_ARC5);
        random_burst(155);
        drain;
        set_variant(VAR_STANDARD);
        random_burst(155);
        drain;
        set_variant(VAR_ARC5);
        random_burst(155);
        drain;

        repeat (10) @(posedge clk);
        if (mismatches == 0 && port_results_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
